// ----- hw/rtl/wcg_pkg.sv -----
package wcg_pkg;

    // Field and register widths
    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;
    localparam int M_W     = 12;
    localparam int COEF_W  = 16;
    localparam int WIN_W   = 3;

    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 15;
    localparam int PHASE_BITS     = 16;

    // Divider: quotient up to 1.0 in Q30, denominator up to (N-1)^2
    localparam int Q_FRAC = 30;
    localparam int DEN_W  = 2 * M_W;
    localparam int D_W    = M_W + 1;
    localparam int D2_W   = 2 * D_W;
    localparam int Q_W    = Q_FRAC + 1;
    localparam int NUM_W  = DEN_W + Q_W;

    // Cosine datapath
    localparam int ANG_W        = 32;
    localparam int Z_W          = 34;
    localparam int XY_W         = 33;
    localparam int COEFK_W      = 32;
    localparam int V_W          = XY_W + COEFK_W - Q_FRAC;
    localparam int NUM_HARM     = 3;
    localparam int CORDIC_STEPS = 30;
    localparam longint CORDIC_GAIN = 652032874;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam longint ONE_Q30 = longint'(1) <<< Q_FRAC;

    // Window constants in Q30, rounded half up
    localparam longint HAM_A0 = ((longint'(25) <<< Q_FRAC) + 46 / 2) / 46;
    localparam longint BLK_A0 = ((longint'(42) <<< Q_FRAC) + 100 / 2) / 100;
    localparam longint BLK_A1 = ((longint'(1) <<< Q_FRAC) + 2 / 2) / 2;
    localparam longint BLK_A2 = ((longint'(8) <<< Q_FRAC) + 100 / 2) / 100;
    localparam longint BH_A0  = ((longint'(35875) <<< Q_FRAC) + 100000 / 2) / 100000;
    localparam longint BH_A1  = ((longint'(48829) <<< Q_FRAC) + 100000 / 2) / 100000;
    localparam longint BH_A2  = ((longint'(14128) <<< Q_FRAC) + 100000 / 2) / 100000;
    localparam longint BH_A3  = ((longint'(1168) <<< Q_FRAC) + 100000 / 2) / 100000;

    // Arctangents in units of 2^-32 turn
    localparam int ATAN_TURNS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef enum logic [WIN_W-1:0] {
        WIN_HAMMING         = 3'd0,
        WIN_HANN            = 3'd1,
        WIN_CONSTANT        = 3'd2,
        WIN_BARTLETT        = 3'd3,
        WIN_BLACKMAN        = 3'd4,
        WIN_BLACKMAN_HARRIS = 3'd5,
        WIN_WELCH           = 3'd6
    } win_t;

    typedef enum logic {
        REG_WINDOW_TYPE   = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } cfg_reg_t;

    typedef logic signed [Z_W-1:0]  zval_t;
    typedef logic signed [XY_W-1:0] xyval_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [M_W-1:0]   m;
        logic [WIN_W-1:0] win;
        logic             oor;
        logic             one;
    } entry_t;

    typedef struct packed {
        logic [WIN_W-1:0] win;
        logic             oor;
        logic             one;
        logic [Q_W-1:0]   q;
    } tag_t;

    // Weight of one cosine harmonic, negated when the angle was folded
    function automatic logic signed [COEFK_W-1:0] lane_coef(
        input logic [WIN_W-1:0] win,
        input int               lane,
        input logic             neg
    );
        longint c;
        c = 0;
        unique case (win)
            WIN_HAMMING: begin
                if (lane == 0) c = ONE_Q30 - HAM_A0;
            end
            WIN_BLACKMAN: begin
                if (lane == 0)      c = BLK_A1;
                else if (lane == 1) c = BLK_A2;
            end
            WIN_BLACKMAN_HARRIS: begin
                if (lane == 0)      c = BH_A1;
                else if (lane == 1) c = BH_A2;
                else                c = BH_A3;
            end
            default: c = 0;
        endcase
        if (neg) c = -c;
        return COEFK_W'(c);
    endfunction

    function automatic logic signed [V_W-1:0] base_q30(input logic [WIN_W-1:0] win);
        longint c;
        unique case (win)
            WIN_HAMMING:         c = HAM_A0;
            WIN_BLACKMAN:        c = BLK_A0;
            WIN_BLACKMAN_HARRIS: c = BH_A0;
            default:             c = 0;
        endcase
        return V_W'(c);
    endfunction

endpackage

// ----- hw/rtl/wcg_front.sv -----
module wcg_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [wcg_pkg::IDX_W-1:0]   sample_index,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [wcg_pkg::LEN_W-1:0]   cfg_data,
    output logic                        head_valid,
    output wcg_pkg::entry_t             head,
    input  logic                        pop
);
    import wcg_pkg::*;

    logic [WIN_W-1:0]    win_type_reg;
    logic [LEN_W-1:0]    win_length_reg;
    entry_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic [LEN_W-1:0]    len_eff;
    entry_t              entry_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_type_reg   <= WIN_W'(WIN_HAMMING);
            win_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_TYPE:   win_type_reg   <= cfg_data[WIN_W-1:0];
                REG_WINDOW_LENGTH: win_length_reg <= cfg_data;
                default:           win_length_reg <= win_length_reg;
            endcase
        end
    end

    // Classify the beat on the way in
    always_comb
    begin
        len_eff = (win_length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                        : win_length_reg;
        entry_c.index = sample_index;
        entry_c.m     = M_W'(len_eff - LEN_W'(1));
        entry_c.win   = win_type_reg;
        entry_c.oor   = LEN_W'(sample_index) >= len_eff;
        entry_c.one   = len_eff == LEN_W'(1);
    end

    assign in_ready   = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign push       = in_valid && in_ready;
    assign head_valid = count_reg != '0;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) queue_reg[wr_ptr_reg] <= entry_c;
    end

endmodule

// ----- hw/rtl/wcg_div.sv -----
module wcg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [wcg_pkg::NUM_W-1:0]   in_num,
    input  logic [wcg_pkg::DEN_W-1:0]   in_den,
    input  wcg_pkg::tag_t               in_tag,
    output logic                        out_valid,
    output logic [wcg_pkg::Q_W-1:0]     out_q,
    output wcg_pkg::tag_t               out_tag
);
    import wcg_pkg::*;

    logic [Q_W:0]       valid_reg;
    tag_t               tag_reg [Q_W+1];
    logic [Q_W-1:0]     quo_reg [Q_W+1];
    logic [DEN_W-1:0]   rem_reg [Q_W];
    logic [Q_W-1:0]     low_reg [Q_W];
    logic [DEN_W-1:0]   den_reg [Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[Q_W-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int s = 0; s < Q_W; s++)
                tag_reg[s+1] <= tag_reg[s];
            rem_reg[0] <= in_num[NUM_W-1:Q_W];
            low_reg[0] <= in_num[Q_W-1:0];
            den_reg[0] <= in_den;
            quo_reg[0] <= '0;
        end
    end

    // One quotient bit per stage, restoring
    for (genvar s = 0; s < Q_W; s++)
    begin : g_step
        logic [DEN_W:0] shifted;
        logic           ge;
        logic [DEN_W:0] diff;

        assign shifted = {rem_reg[s], low_reg[s][Q_W-1]};
        assign ge      = shifted >= {1'b0, den_reg[s]};
        assign diff    = shifted - {1'b0, den_reg[s]};

        always_ff @(posedge clk)
        begin
            if (en)
                quo_reg[s+1] <= {quo_reg[s][Q_W-2:0], ge};
        end

        if (s < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                    low_reg[s+1] <= {low_reg[s][Q_W-2:0], 1'b0};
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_q     = quo_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

// ----- hw/rtl/wcg_cordic.sv -----
module wcg_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  wcg_pkg::zval_t  in_z [wcg_pkg::NUM_HARM],
    input  logic            in_neg [wcg_pkg::NUM_HARM],
    input  wcg_pkg::tag_t   in_tag,
    output logic            out_valid,
    output wcg_pkg::xyval_t out_x [wcg_pkg::NUM_HARM],
    output logic            out_neg [wcg_pkg::NUM_HARM],
    output wcg_pkg::tag_t   out_tag
);
    import wcg_pkg::*;

    logic [CORDIC_STEPS:0] valid_reg;
    tag_t                  tag_reg [CORDIC_STEPS+1];
    logic                  neg_reg [CORDIC_STEPS+1][NUM_HARM];
    xyval_t                x_reg   [CORDIC_STEPS+1][NUM_HARM];
    xyval_t                y_reg   [CORDIC_STEPS][NUM_HARM];
    zval_t                 z_reg   [CORDIC_STEPS][NUM_HARM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int s = 0; s < CORDIC_STEPS; s++)
                tag_reg[s+1] <= tag_reg[s];
            for (int l = 0; l < NUM_HARM; l++)
            begin
                neg_reg[0][l] <= in_neg[l];
                x_reg[0][l]   <= XY_W'(CORDIC_GAIN);
                y_reg[0][l]   <= '0;
                z_reg[0][l]   <= in_z[l];
                for (int s = 0; s < CORDIC_STEPS; s++)
                    neg_reg[s+1][l] <= neg_reg[s][l];
            end
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_stage
        for (genvar l = 0; l < NUM_HARM; l++)
        begin : g_lane
            logic   rot_pos;
            xyval_t sx;
            xyval_t sy;

            // Rotate toward zero residual angle
            assign rot_pos = !z_reg[s][l][Z_W-1];
            assign sx      = x_reg[s][l] >>> s;
            assign sy      = y_reg[s][l] >>> s;

            always_ff @(posedge clk)
            begin
                if (en)
                    x_reg[s+1][l] <= rot_pos ? x_reg[s][l] - sy : x_reg[s][l] + sy;
            end

            if (s < CORDIC_STEPS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        y_reg[s+1][l] <= rot_pos ? y_reg[s][l] + sx : y_reg[s][l] - sx;
                        z_reg[s+1][l] <= rot_pos ? z_reg[s][l] - Z_W'(ATAN_TURNS[s])
                                                 : z_reg[s][l] + Z_W'(ATAN_TURNS[s]);
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < NUM_HARM; l++)
    begin : g_out
        assign out_x[l]   = x_reg[CORDIC_STEPS][l];
        assign out_neg[l] = neg_reg[CORDIC_STEPS][l];
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_tag   = tag_reg[CORDIC_STEPS];

endmodule

// ----- hw/rtl/wcg_back.sv -----
module wcg_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  wcg_pkg::entry_t              head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wcg_pkg::COEF_W-1:0]   coefficient,
    output logic                         index_out_of_range
);
    import wcg_pkg::*;

    localparam logic signed [V_W-1:0] ONE_V   = V_W'(ONE_Q30);
    localparam logic signed [V_W-1:0] ROUND_V = V_W'(1) <<< (Q_FRAC - 1 - COEF_FRAC_BITS);
    localparam logic [ANG_W-1:0]      QUARTER = ANG_W'(1) << (ANG_W - 2);

    logic en;

    // Stage 1: distance from center and squares
    logic                 s1_valid_reg;
    entry_t               s1_entry_reg;
    logic [D_W-1:0]       s1_d_reg;
    logic [DEN_W-1:0]     s1_m2_reg;
    logic [D2_W-1:0]      s1_d2_reg;
    logic [D_W-1:0]       two_n;
    logic [D_W-1:0]       m_ext;
    logic [D_W-1:0]       d_c;

    // Divider operands
    logic [NUM_W-1:0]     num_c;
    logic [DEN_W-1:0]     den_c;
    tag_t                 s1_tag_c;

    logic                 div_valid;
    logic [Q_W-1:0]       div_q;
    tag_t                 div_tag;
    tag_t                 ang_tag_c;
    zval_t                z_c    [NUM_HARM];
    logic                 zneg_c [NUM_HARM];

    logic                 cor_valid;
    xyval_t               cor_x   [NUM_HARM];
    logic                 cor_neg [NUM_HARM];
    tag_t                 cor_tag;

    // Stage 4: harmonic products
    logic                    s4_valid_reg;
    tag_t                    s4_tag_reg;
    logic signed [V_W-1:0]   s4_p_reg [NUM_HARM];
    logic signed [V_W-1:0]   s4_hann_reg;
    logic signed [V_W-1:0]   p_c [NUM_HARM];
    logic signed [V_W-1:0]   hann_sum;

    // Stage 5: weight before clamp
    logic                    s5_valid_reg;
    logic                    s5_oor_reg;
    logic signed [V_W-1:0]   s5_v_reg;
    logic signed [V_W-1:0]   v_c;

    logic                    out_valid_reg;
    logic [COEF_W-1:0]       coef_reg;
    logic                    oor_reg;
    logic signed [V_W-1:0]   vc;
    logic signed [V_W-1:0]   vr;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && head_valid;

    always_comb
    begin
        two_n = {head.index, 1'b0};
        m_ext = D_W'(head.m);
        d_c   = (two_n >= m_ext) ? two_n - m_ext : m_ext - two_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_entry_reg <= head;
            s1_d_reg     <= d_c;
            s1_m2_reg    <= DEN_W'(head.m) * DEN_W'(head.m);
            s1_d2_reg    <= D2_W'(d_c) * D2_W'(d_c);
        end
    end

    always_comb
    begin
        unique case (s1_entry_reg.win)
            WIN_BARTLETT:
            begin
                num_c = (NUM_W'(M_W'(s1_entry_reg.m - s1_d_reg[M_W-1:0])) << Q_FRAC)
                      + NUM_W'(s1_entry_reg.m >> 1);
                den_c = DEN_W'(s1_entry_reg.m);
            end
            WIN_WELCH:
            begin
                num_c = (NUM_W'(DEN_W'(s1_m2_reg - s1_d2_reg[DEN_W-1:0])) << Q_FRAC)
                      + NUM_W'(s1_m2_reg >> 1);
                den_c = s1_m2_reg;
            end
            default:
            begin
                num_c = (NUM_W'(s1_entry_reg.index) << PHASE_BITS)
                      + NUM_W'(s1_entry_reg.m >> 1);
                den_c = DEN_W'(s1_entry_reg.m);
            end
        endcase
        // Single-sample and empty windows never use the quotient
        if (den_c == '0) den_c = DEN_W'(1);
        s1_tag_c.win = s1_entry_reg.win;
        s1_tag_c.oor = s1_entry_reg.oor;
        s1_tag_c.one = s1_entry_reg.one;
        s1_tag_c.q   = '0;
    end

    wcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_num    (num_c),
        .in_den    (den_c),
        .in_tag    (s1_tag_c),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_tag   (div_tag)
    );

    // Harmonic angles, folded into the right half-plane
    always_comb
    begin
        logic [PHASE_BITS-1:0] pk;
        logic [ANG_W-1:0]      ang;
        logic [ANG_W-1:0]      t;
        ang_tag_c   = div_tag;
        ang_tag_c.q = div_q;
        for (int l = 0; l < NUM_HARM; l++)
        begin
            pk        = PHASE_BITS'(div_q[PHASE_BITS-1:0] * PHASE_BITS'(l + 1));
            ang       = {pk, {(ANG_W - PHASE_BITS){1'b0}}};
            t         = ang + QUARTER;
            zneg_c[l] = t[ANG_W-1];
            ang[ANG_W-1] = ang[ANG_W-1] ^ t[ANG_W-1];
            z_c[l]    = Z_W'(signed'(ang));
        end
    end

    wcg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_z      (z_c),
        .in_neg    (zneg_c),
        .in_tag    (ang_tag_c),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_neg   (cor_neg),
        .out_tag   (cor_tag)
    );

    for (genvar l = 0; l < NUM_HARM; l++)
    begin : g_mul
        logic signed [COEFK_W-1:0]      k;
        logic signed [XY_W+COEFK_W-1:0] prod;

        // Fold the sign of the cosine into the weight
        assign k      = lane_coef(cor_tag.win, l, cor_neg[l]);
        assign prod   = cor_x[l] * k;
        assign p_c[l] = signed'(prod[XY_W+COEFK_W-1:Q_FRAC]);
    end

    assign hann_sum = cor_neg[0] ? ONE_V + V_W'(cor_x[0]) : ONE_V - V_W'(cor_x[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg  <= cor_valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_tag_reg  <= cor_tag;
            s4_hann_reg <= hann_sum >>> 1;
            for (int l = 0; l < NUM_HARM; l++)
                s4_p_reg[l] <= p_c[l];
        end
    end

    always_comb
    begin
        if (s4_tag_reg.one)
            v_c = ONE_V;
        else
        begin
            unique case (s4_tag_reg.win)
                WIN_HAMMING, WIN_BLACKMAN, WIN_BLACKMAN_HARRIS:
                    v_c = base_q30(s4_tag_reg.win) - s4_p_reg[0] + s4_p_reg[1] - s4_p_reg[2];
                WIN_HANN:
                    v_c = s4_hann_reg;
                WIN_BARTLETT, WIN_WELCH:
                    v_c = V_W'(s4_tag_reg.q);
                default:
                    v_c = ONE_V;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_v_reg   <= v_c;
            s5_oor_reg <= s4_tag_reg.oor;
        end
    end

    // Clamp to 0..1.0, round half up
    always_comb
    begin
        if (s5_v_reg < 0)
            vc = '0;
        else if (s5_v_reg > ONE_V)
            vc = ONE_V;
        else
            vc = s5_v_reg;
        vr = (vc + ROUND_V) >>> (Q_FRAC - COEF_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= s5_oor_reg ? '0 : COEF_W'(vr);
            oor_reg  <= s5_oor_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign coefficient        = coef_reg;
    assign index_out_of_range = oor_reg;

endmodule

// ----- hw/rtl/window_coefficient_generator.sv -----
// Window coefficient generator.
// Slave stream s_axis carries a sample index; master stream m_axis returns
// that sample's window weight in unsigned Q1.15 (32768 = 1.0) and a flag in
// tuser set when the index is not below the window length (weight then 0).
// Window type and length are written on the cfg port (index 0 type,
// index 1 length) while no beats are in flight.
// While m_axis_tready is high, one beat per cycle is accepted and returned in
// steady state. A beat accepted on s_axis passes the input queue, a 31-stage
// radix-2 divider for the phase or ratio, a 30-stage CORDIC with one lane per
// harmonic, then multiply, sum and round stages before it reaches m_axis.
// When m_axis_tready is low the whole back pipeline holds; the four-entry
// input queue keeps s_axis_tready high until it fills.
// Reset selects a Hamming window of length 1 and empties the pipeline.
module window_coefficient_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [11:0] sample_index
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [15:0] coefficient
    output logic [0:0]                  m_axis_tuser,   // [0] index_out_of_range
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [wcg_pkg::LEN_W-1:0]   cfg_data
);
    import wcg_pkg::*;

    logic   head_valid;
    entry_t head;
    logic   pop;
    logic   oor;

    wcg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .sample_index (s_axis_tdata[IDX_W-1:0]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index[0]),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    wcg_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (head_valid),
        .head               (head),
        .pop                (pop),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .coefficient        (m_axis_tdata),
        .index_out_of_range (oor)
    );

    assign m_axis_tuser = oor;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import wcg_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [LEN_W-1:0] cfg_data;

    typedef struct {
        logic [15:0] coef;
        logic        oor;
    } weight_t;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 100;

    logic [2:0]       cur_win;
    logic [LEN_W-1:0] cur_len;
    weight_t          pending_weights[$];
    int               mismatch_count;
    int               idle_count;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_recv;
    bit               timed_out;

    window_coefficient_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_const(longint num, longint den);
        return ((num <<< 30) + den / 2) / den;
    endfunction

    // integer CORDIC cosine, angle in 2^-32 turn, result in Q30
    function automatic longint cordic_cos(logic [31:0] turn);
        logic [31:0] a;
        bit          flip;
        longint      x, y, z, dx, dy;
        a = turn;
        flip = 0;
        x = 652032874;
        y = 0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0)
        begin
            a = a + 32'h8000_0000;
            flip = 1;
        end
        z = a[31] ? longint'({32'b0, a}) - (longint'(1) <<< 32) : longint'({32'b0, a});
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        return flip ? -x : x;
    endfunction

    function automatic longint harmonic_cos(longint p, longint k);
        logic [63:0] prod;
        prod = (k * p) << (32 - PHASE_BITS);
        return cordic_cos(prod[31:0]);
    endfunction

    function automatic longint scale_q30(longint c, longint v);
        return floor_shift(c * v, 30);
    endfunction

    function automatic weight_t predict_weight(logic [11:0] idx);
        weight_t w;
        longint  n, len, m, p, d, m2, v, a0;
        n = idx;
        len = cur_len;
        if (len > MAX_LENGTH)
            len = MAX_LENGTH;
        w.coef = 0;
        w.oor = 0;
        if (n >= len)
        begin
            w.oor = 1;
            return w;
        end
        if (len == 1)
            v = longint'(1) <<< 30;
        else
        begin
            m = len - 1;
            p = ((n <<< PHASE_BITS) + m / 2) / m;
            d = (2 * n >= m) ? 2 * n - m : m - 2 * n;
            case (cur_win)
                WIN_HAMMING:
                begin
                    a0 = q30_const(25, 46);
                    v = a0 - scale_q30((longint'(1) <<< 30) - a0, harmonic_cos(p, 1));
                end
                WIN_HANN:
                    v = floor_shift((longint'(1) <<< 30) - harmonic_cos(p, 1), 1);
                WIN_BARTLETT:
                    v = (((m - d) <<< 30) + m / 2) / m;
                WIN_BLACKMAN:
                    v = q30_const(42, 100) - scale_q30(q30_const(1, 2), harmonic_cos(p, 1))
                        + scale_q30(q30_const(8, 100), harmonic_cos(p, 2));
                WIN_BLACKMAN_HARRIS:
                    v = q30_const(35875, 100000)
                        - scale_q30(q30_const(48829, 100000), harmonic_cos(p, 1))
                        + scale_q30(q30_const(14128, 100000), harmonic_cos(p, 2))
                        - scale_q30(q30_const(1168, 100000), harmonic_cos(p, 3));
                WIN_WELCH:
                begin
                    m2 = m * m;
                    v = (((m2 - d * d) <<< 30) + m2 / 2) / m2;
                end
                default:
                    v = longint'(1) <<< 30;
            endcase
        end
        if (v < 0)
            v = 0;
        if (v > (longint'(1) <<< 30))
            v = longint'(1) <<< 30;
        v = (v + (longint'(1) <<< (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
        w.coef = v[15:0];
        return w;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [LEN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        if (idx == REG_WINDOW_TYPE)
            cur_win = value[2:0];
        else
            cur_len = value;
    endtask

    task automatic set_window(logic [2:0] win, logic [LEN_W-1:0] len);
        write_reg(REG_WINDOW_TYPE, LEN_W'(win));
        write_reg(REG_WINDOW_LENGTH, len);
        cfg_we <= 1'b0;
    endtask

    task automatic send_index(logic [11:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_weights.push_back(predict_weight(idx));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_weights.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [11:0] pick_index(logic [LEN_W-1:0] len);
        if (len != 0 && $urandom_range(9) != 0)
            return 12'($urandom_range((len > 4096 ? 4096 : len) - 1));
        return 12'($urandom_range(4095));
    endfunction

    task automatic test_edges();
        logic [2:0] w;
        set_window(WIN_HAMMING, 1);
        send_index(0);
        send_index(1);
        send_index(12'hFFF);
        wait_drained();
        set_window(WIN_CONSTANT, 0);
        send_index(0);
        send_index(12'hAAA);
        wait_drained();
        for (int t = 0; t < 8; t++)
        begin
            w = 3'(t);
            set_window(w, 5);
            send_index(0);
            send_index(2);
            send_index(4);
            wait_drained();
        end
        set_window(WIN_BLACKMAN, 13'h1FFF);
        send_index(0);
        send_index(12'd2048);
        send_index(12'hFFF);
        wait_drained();
        set_window(WIN_WELCH, 4096);
        send_index(12'h555);
        send_index(12'hFFF);
        wait_drained();
    endtask

    task automatic run_phase(int sidle, int rstall, int count);
        logic [2:0]       w;
        logic [LEN_W-1:0] len;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                wait_drained();
                w = 3'($urandom_range(7));
                case ($urandom_range(5))
                    0: len = LEN_W'($urandom_range(4));
                    1: len = LEN_W'($urandom_range(13'h1FFF));
                    2: len = 4096;
                    default: len = LEN_W'($urandom_range(64, 2));
                endcase
                set_window(w, len);
            end
            send_index(pick_index(cur_len));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_window(WIN_BLACKMAN_HARRIS, 100);
        hold_recv = 1;
        fork
            begin
                repeat (150) @(negedge clk);
                hold_recv = 0;
            end
            for (int i = 0; i < 90; i++)
                send_index(12'($urandom_range(99)));
        join
        wait_drained();
    endtask

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n || hold_recv)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        weight_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_weights.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: coef=%0d oor=%0b", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_weights.pop_front();
                if (want.coef !== m_axis_tdata || want.oor !== m_axis_tuser[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want coef=%0d oor=%0b got coef=%0d oor=%0b",
                                 want.coef, want.oor, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or cfg write while beats are pending or offered
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we
            || (pending_weights.size() == 0 && !s_axis_tvalid))
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count > WATCHDOG_CYCLES)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_win = WIN_HAMMING;
        cur_len = 1;
        mismatch_count = 0;
        idle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_edges();
        test_backpressure();
        run_phase(0, 0, 240);
        run_phase(88, 0, 160);
        run_phase(0, 88, 160);
        run_phase(31, 31, 200);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/wcg_pkg.sv
hw/rtl/wcg_front.sv
hw/rtl/wcg_div.sv
hw/rtl/wcg_cordic.sv
hw/rtl/wcg_back.sv
hw/rtl/window_coefficient_generator.sv
test/testbench.sv
